// ===== design/vn_pkg.sv =====
// Shared constants for the vector normalize pipeline.
package vn_pkg;

   localparam int UNIT_FRAC_BITS = 30;               // Q1.30 unit components
   localparam int QUOT_W         = UNIT_FRAC_BITS + 1; // quotient magnitude <= 2^30
   localparam int FIELD_W        = 32;               // width of every payload field
   localparam int LANES          = 3;

   typedef logic [FIELD_W-1:0] field_type;

endpackage

// ===== design/vector3_normalize_core.sv =====
// Pipelined 3D vector normalizer: length by floor square root, unit components by division.
//
// Usage:
//   Input channel req_*: one Q16.16 vector (x, y, z) per item, taken at a rising
//   edge where req_valid is high and req_stall is low.
//   Result channel rsp_*: unit components in signed Q1.30 (truncated toward
//   zero), the length in unsigned Q16.16 and a zero-vector flag, taken at an
//   edge where rsp_valid is high and rsp_stall is low.
//   The pipeline has three stages for magnitude, squares and sum, one stage per
//   root bit of the square root, one stage per quotient bit of the three
//   dividers, and one output stage. One item can enter every cycle while
//   req_stall is low.
//   Every stage holds its own valid bit. A stall from the receiver holds only
//   the stages that are full up to the first empty one, so bubbles are squeezed
//   out and the input keeps taking items while a result waits, until all are full.
//   Reset (synchronous) empties the pipeline; no data is kept across items.
//   A zero vector gives zero unit components, zero length and the flag set.
module vector3_normalize_core #(
   parameter int COMPONENT_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  vn_pkg::field_type   req_vec_x,
   input  vn_pkg::field_type   req_vec_y,
   input  vn_pkg::field_type   req_vec_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output vn_pkg::field_type   rsp_unit_x,
   output vn_pkg::field_type   rsp_unit_y,
   output vn_pkg::field_type   rsp_unit_z,
   output vn_pkg::field_type   rsp_vec_length,
   output logic                rsp_zero_vector
);
   import vn_pkg::*;

   localparam int CW     = COMPONENT_WIDTH;
   localparam int SW     = 2 * CW;          // sum of squares width
   localparam int RW     = CW + 3;          // square root remainder width
   localparam int SQ0    = 3;               // first root stage
   localparam int DV0    = SQ0 + CW;        // first divide stage
   localparam int NS     = DV0 + QUOT_W + 1;
   localparam int OS     = NS - 1;

   logic [NS-1:0] valid_ff;
   logic [NS:0]   en;

   // stage i loads when it is empty or its content moves on
   always_comb begin
      en[NS] = !rsp_stall;
      for (int i = NS - 1; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) valid_ff[0] <= req_valid;
         for (int i = 1; i < NS; i++) begin
            if (en[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[OS];

   // ---- stage 0: sign and magnitude
   logic [LANES-1:0][CW-1:0] comp;
   logic [LANES-1:0][CW-1:0] mag0_ff, mag0_in;
   logic [LANES-1:0]         neg0_ff, neg0_in;

   assign comp[0] = req_vec_x[CW-1:0];
   assign comp[1] = req_vec_y[CW-1:0];
   assign comp[2] = req_vec_z[CW-1:0];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         neg0_in[l] = comp[l][CW-1];
         mag0_in[l] = neg0_in[l] ? CW'(-comp[l]) : comp[l];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mag0_ff <= mag0_in;
         neg0_ff <= neg0_in;
      end
   end

   // ---- stage 1: squares
   logic [LANES-1:0][SW-1:0] sq1_ff, sq1_in;
   logic [LANES-1:0][CW-1:0] mag1_ff;
   logic [LANES-1:0]         neg1_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         sq1_in[l] = SW'(mag0_ff[l]) * SW'(mag0_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         sq1_ff  <= sq1_in;
         mag1_ff <= mag0_ff;
         neg1_ff <= neg0_ff;
      end
   end

   // ---- stage 2: sum of squares (fits SW bits)
   logic [SW-1:0]            sum2_ff, sum2_in;
   logic [LANES-1:0][CW-1:0] mag2_ff;
   logic [LANES-1:0]         neg2_ff;

   assign sum2_in = sq1_ff[0] + sq1_ff[1] + sq1_ff[2];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         sum2_ff <= sum2_in;
         mag2_ff <= mag1_ff;
         neg2_ff <= neg1_ff;
      end
   end

   // ---- square root: one root bit per stage
   logic [CW-1:0][SW-1:0]             sqn_ff;
   logic [CW-1:0][RW-1:0]             sqrem_ff;
   logic [CW-1:0][CW-1:0]             sqroot_ff;
   logic [CW-1:0][LANES-1:0][CW-1:0]  sqmag_ff;
   logic [CW-1:0][LANES-1:0]          sqneg_ff;

   for (genvar k = 0; k < CW; k++) begin : g_sqrt
      logic [SW-1:0]            src_n;
      logic [RW-1:0]            src_rem;
      logic [CW-1:0]            src_root;
      logic [LANES-1:0][CW-1:0] src_mag;
      logic [LANES-1:0]         src_neg;
      logic [RW-1:0]            rem_sh;
      logic [RW-1:0]            trial;
      logic                     ge;
      logic [SW-1:0]            n_in;
      logic [RW-1:0]            rem_in;
      logic [CW-1:0]            root_in;

      if (k == 0) begin : g_first
         assign src_n    = sum2_ff;
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_mag  = mag2_ff;
         assign src_neg  = neg2_ff;
      end else begin : g_next
         assign src_n    = sqn_ff[k-1];
         assign src_rem  = sqrem_ff[k-1];
         assign src_root = sqroot_ff[k-1];
         assign src_mag  = sqmag_ff[k-1];
         assign src_neg  = sqneg_ff[k-1];
      end

      assign rem_sh  = {src_rem[RW-3:0], src_n[SW-1 -: 2]};
      assign trial   = RW'({src_root, 2'b01});
      assign ge      = rem_sh >= trial;
      assign rem_in  = ge ? rem_sh - trial : rem_sh;
      assign root_in = {src_root[CW-2:0], ge};
      assign n_in    = {src_n[SW-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (en[SQ0+k]) begin
            sqn_ff[k]    <= n_in;
            sqrem_ff[k]  <= rem_in;
            sqroot_ff[k] <= root_in;
            sqmag_ff[k]  <= src_mag;
            sqneg_ff[k]  <= src_neg;
         end
      end
   end

   // ---- dividers: (mag << 30) / len, one quotient bit per stage and lane.
   // The top part mag >> 1 is below len, so the first step starts from mag.
   logic [QUOT_W-1:0][LANES-1:0][CW-1:0]     dvrem_ff;
   logic [QUOT_W-1:0][LANES-1:0][QUOT_W-1:0] dvq_ff;
   logic [QUOT_W-1:0][CW-1:0]                dvlen_ff;
   logic [QUOT_W-1:0][LANES-1:0]             dvneg_ff;

   for (genvar j = 0; j < QUOT_W; j++) begin : g_div
      logic [CW-1:0]                src_len;
      logic [LANES-1:0]             src_neg;
      logic [LANES-1:0][CW:0]       part;
      logic [LANES-1:0][QUOT_W-1:0] src_q;
      logic [LANES-1:0][CW-1:0]     rem_in;
      logic [LANES-1:0][QUOT_W-1:0] q_in;

      if (j == 0) begin : g_first
         assign src_len = sqroot_ff[CW-1];
         assign src_neg = sqneg_ff[CW-1];
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign part[l]  = {1'b0, sqmag_ff[CW-1][l]};
            assign src_q[l] = '0;
         end
      end else begin : g_next
         assign src_len = dvlen_ff[j-1];
         assign src_neg = dvneg_ff[j-1];
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign part[l]  = {dvrem_ff[j-1][l], 1'b0};
            assign src_q[l] = dvq_ff[j-1][l];
         end
      end

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            if (part[l] >= {1'b0, src_len}) begin
               rem_in[l] = CW'(part[l] - {1'b0, src_len});
               q_in[l]   = {src_q[l][QUOT_W-2:0], 1'b1};
            end else begin
               rem_in[l] = part[l][CW-1:0];
               q_in[l]   = {src_q[l][QUOT_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[DV0+j]) begin
            dvrem_ff[j] <= rem_in;
            dvq_ff[j]   <= q_in;
            dvlen_ff[j] <= src_len;
            dvneg_ff[j] <= src_neg;
         end
      end
   end

   // ---- output stage: sign, zero vector
   logic [LANES-1:0][FIELD_W-1:0] unit_ff, unit_in;
   logic [FIELD_W-1:0]            len_ff, len_in;
   logic                          zero_ff, zero_in;
   logic [FIELD_W-1:0]            qext;

   always_comb begin
      zero_in = dvlen_ff[QUOT_W-1] == '0;
      len_in  = FIELD_W'(dvlen_ff[QUOT_W-1]);
      qext    = '0;
      for (int l = 0; l < LANES; l++) begin
         qext = FIELD_W'(dvq_ff[QUOT_W-1][l]);
         if (zero_in) begin
            unit_in[l] = '0;
         end else if (dvneg_ff[QUOT_W-1][l]) begin
            unit_in[l] = -qext;
         end else begin
            unit_in[l] = qext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[OS]) begin
         unit_ff <= unit_in;
         len_ff  <= len_in;
         zero_ff <= zero_in;
      end
   end

   assign rsp_unit_x      = unit_ff[0];
   assign rsp_unit_y      = unit_ff[1];
   assign rsp_unit_z      = unit_ff[2];
   assign rsp_vec_length  = len_ff;
   assign rsp_zero_vector = zero_ff;

endmodule
